// ===== rtl/core/egm_pkg.sv =====
`default_nettype none

package egm_pkg;

  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned PixelBitsDef = 16;

  localparam int unsigned CfgW   = 19;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SRC_NODATA   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DST_NODATA   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OUT_MIN      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OUT_MAX      = 3'd6;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic MODE_ROBERTS = 1'b0;
  localparam logic MODE_SOBEL   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT1,
    ST_EMIT2,
    ST_DRAIN
  } egm_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/egm_line_mem.sv =====
`default_nettype none

module egm_line_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned DATA_W = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/egm_isqrt.sv =====
`default_nettype none

module egm_isqrt #(
  parameter int unsigned RB = 20,
  localparam int unsigned SB = 2 * RB,
  localparam int unsigned CB = $clog2(RB + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [SB-1:0] radicand,
  output logic               done,
  output logic      [RB-1:0] root
);

  logic [SB-1:0] rem;
  logic [SB-1:0] res;
  logic [SB-1:0] bitv;
  logic [CB-1:0] count;
  logic          busy;
  logic [SB-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[RB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CB'(RB);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitv <= SB'(1) << (SB - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/edge_gradient_magnitude.sv =====
// Channel  Dir  Handshake            Beat
// in       in   in_valid / in_stall  cmd, pixel
// out      out  out_valid / out_stall magnitude, out_col, out_row, is_nodata,
//                                    frame_end, run_end
// cfg      in   cfg_write_en         cfg_index, cfg_data
// One item at a time. A computed pixel passes ST_READ, ST_SQUARE, ST_ROOT
// (square root unit, one result bit per cycle) and ST_EMIT1, then ST_EMIT2
// when a row-end beat follows; a border-only pixel skips ST_ROOT, a first-row
// pixel emits nothing. Line buffers are read and written once per pixel. rst
// is synchronous and clears counters, window and control; the line buffers
// hold no reset. A stalled output holds the sequencer in place.
`default_nettype none

module edge_gradient_magnitude
  import egm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [15:0]        pixel,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [18:0]        magnitude,
  output logic      [11:0]        out_col,
  output logic      [15:0]        out_row,
  output logic                    is_nodata,
  output logic                    frame_end,
  output logic                    run_end,
  input  wire logic               cfg_write_en,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned GB = PB + 3;
  localparam int unsigned RB = GB + 1;
  localparam int unsigned SB = 2 * RB;

  logic        filter_mode;
  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [15:0] src_nodata;
  logic [18:0] dst_nodata;
  logic [18:0] out_min;
  logic [18:0] out_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_SOBEL;
      image_width  <= 13'd4096;
      image_height <= 16'd1;
      src_nodata   <= '0;
      dst_nodata   <= '0;
      out_min      <= '0;
      out_max      <= 19'd65535;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[15:0];
        REG_SRC_NODATA:   src_nodata   <= cfg_data[15:0];
        REG_DST_NODATA:   dst_nodata   <= cfg_data;
        REG_OUT_MIN:      out_min      <= cfg_data;
        REG_OUT_MAX:      out_max      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] wm1;
  logic [15:0]   hm1;

  always_comb begin
    if (image_width == '0) begin
      wm1 = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(32'(image_width) - 32'd1);
    end
    hm1 = (image_height == '0) ? 16'd0 : image_height - 16'd1;
  end

  egm_state_t state, state_next;

  logic [CW-1:0] in_col;
  logic [15:0]   in_row;
  logic [CW:0]   drain_col;
  logic [PB-1:0] win [6];
  logic [PB-1:0] pix;
  logic [PB-1:0] rd_above;
  logic [PB-1:0] rd_two;

  logic          accept;
  logic          out_free;
  logic          rows_done;
  logic          row_end;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign rows_done = in_row > hm1;
  assign row_end   = in_col >= wm1;
  assign in_stall  = (state != ST_IDLE);

  logic mem_rd;
  logic mem_wr;
  assign mem_rd = accept && (cmd == CMD_PIXEL);
  assign mem_wr = (state == ST_READ);

  egm_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(PB)) u_line_above (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (in_col),
    .wr_data (pix),
    .rd_en   (mem_rd),
    .rd_addr (in_col),
    .rd_data (rd_above)
  );

  egm_line_mem #(.DEPTH(MAX_WIDTH), .DATA_W(PB)) u_line_two (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (in_col),
    .wr_data (rd_above),
    .rd_en   (mem_rd),
    .rd_addr (in_col),
    .rd_data (rd_two)
  );

  function automatic logic signed [GB-1:0] ext(input logic [PB-1:0] p);
    ext = $signed({3'b000, p});
  endfunction

  logic [PB-1:0] top0, top1, top2, mid0, mid1, mid2, bot0, bot1, bot2;
  assign top0 = win[0];
  assign top1 = win[1];
  assign top2 = rd_two;
  assign mid0 = win[2];
  assign mid1 = win[3];
  assign mid2 = rd_above;
  assign bot0 = win[4];
  assign bot1 = win[5];
  assign bot2 = pix;

  function automatic logic is_nd(input logic [PB-1:0] p, input logic [15:0] s);
    is_nd = (16'(p) == s);
  endfunction

  logic signed [GB-1:0] grad_a_c, grad_b_c;
  logic                 valid_c;

  always_comb begin
    if (filter_mode == MODE_SOBEL) begin
      grad_a_c = (ext(top2) + (ext(mid2) <<< 1) + ext(bot2))
               - (ext(top0) + (ext(mid0) <<< 1) + ext(bot0));
      grad_b_c = (ext(bot0) + (ext(bot1) <<< 1) + ext(bot2))
               - (ext(top0) + (ext(top1) <<< 1) + ext(top2));
      valid_c  = (in_col >= CW'(2)) && (in_row >= 16'd2)
              && ((in_col - CW'(1)) < wm1) && ((in_row - 16'd1) < hm1)
              && !is_nd(top0, src_nodata) && !is_nd(top1, src_nodata)
              && !is_nd(top2, src_nodata) && !is_nd(mid0, src_nodata)
              && !is_nd(mid2, src_nodata) && !is_nd(bot0, src_nodata)
              && !is_nd(bot1, src_nodata) && !is_nd(bot2, src_nodata);
    end else begin
      grad_a_c = ext(mid1) - ext(bot2);
      grad_b_c = ext(bot1) - ext(mid2);
      valid_c  = ((in_col - CW'(1)) < wm1) && ((in_row - 16'd1) < hm1)
              && !is_nd(mid1, src_nodata) && !is_nd(bot2, src_nodata)
              && !is_nd(bot1, src_nodata) && !is_nd(mid2, src_nodata);
    end
  end

  logic signed [GB-1:0]   grad_a, grad_b;
  logic                   computed;
  logic [2*GB-1:0]        sq_a, sq_b;
  logic                   has1, has2, re1;
  logic [CW-1:0]          col1, col2;
  logic [15:0]            res_row;

  logic                   sq_start;
  logic                   sq_done;
  logic [RB-1:0]          sq_root;
  logic [SB-1:0]          radicand;

  assign sq_a     = $unsigned((2*GB)'(grad_a) * (2*GB)'(grad_a));
  assign sq_b     = $unsigned((2*GB)'(grad_b) * (2*GB)'(grad_b));
  assign sq_start = (state == ST_SQUARE);
  assign radicand = SB'(sq_a) + SB'(sq_b);

  egm_isqrt #(.RB(RB)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  logic [18:0] mag1;
  logic [31:0] clamp_v;

  always_comb begin
    clamp_v = 32'(sq_root);
    if (clamp_v < 32'(out_min)) clamp_v = 32'(out_min);
    if (clamp_v > 32'(out_max)) clamp_v = 32'(out_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_col    <= '0;
      in_row    <= '0;
      drain_col <= '0;
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_READ) begin
        win[0] <= win[1];
        win[1] <= rd_two;
        win[2] <= win[3];
        win[3] <= rd_above;
        win[4] <= win[5];
        win[5] <= pix;
        if (row_end) begin
          in_col    <= '0;
          in_row    <= in_row + 16'd1;
          drain_col <= '0;
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (state == ST_DRAIN && out_free) begin
        if (drain_col >= {1'b0, wm1}) begin
          drain_col <= '0;
          in_row    <= '0;
          in_col    <= '0;
        end else begin
          drain_col <= drain_col + (CW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix <= pixel[PB-1:0];
    end
    if (state == ST_READ) begin
      grad_a   <= grad_a_c;
      grad_b   <= grad_b_c;
      computed <= valid_c;
      has1     <= (in_row != '0) && (in_col != '0);
      has2     <= (in_row != '0) && row_end;
      re1      <= !row_end;
      col1     <= in_col - CW'(1);
      col2     <= in_col;
      res_row  <= in_row - 16'd1;
      mag1     <= dst_nodata;
    end
    if (state == ST_ROOT && sq_done) begin
      mag1 <= clamp_v[18:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_DRAIN) begin
            if (rows_done) state_next = ST_DRAIN;
          end else if (!rows_done) begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:   state_next = ST_SQUARE;
      ST_SQUARE: begin
        if (!has1) state_next = has2 ? ST_EMIT2 : ST_IDLE;
        else if (!computed) state_next = ST_EMIT1;
        else state_next = ST_ROOT;
      end
      ST_ROOT:   if (sq_done) state_next = ST_EMIT1;
      ST_EMIT1:  if (out_free) state_next = has2 ? ST_EMIT2 : ST_IDLE;
      ST_EMIT2:  if (out_free) state_next = ST_IDLE;
      ST_DRAIN:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  logic load;
  assign load = out_free
             && (state == ST_EMIT1 || state == ST_EMIT2 || state == ST_DRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (state)
        ST_EMIT1: begin
          magnitude <= mag1;
          out_col   <= 12'(col1);
          out_row   <= res_row;
          is_nodata <= !computed;
          frame_end <= 1'b0;
          run_end   <= re1;
        end
        ST_EMIT2: begin
          magnitude <= dst_nodata;
          out_col   <= 12'(col2);
          out_row   <= res_row;
          is_nodata <= 1'b1;
          frame_end <= 1'b0;
          run_end   <= 1'b1;
        end
        default: begin
          magnitude <= dst_nodata;
          out_col   <= 12'(drain_col);
          out_row   <= hm1;
          is_nodata <= 1'b1;
          frame_end <= drain_col >= {1'b0, wm1};
          run_end   <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
